// ===== design/i2cbm_pkg.sv =====
// Shared types, codes and helpers for the I2C bit-level master.
package i2cbm_pkg;

	// Command codes carried in the opcode field
	typedef enum logic [2:0] {
		OP_NONE  = 3'd0,
		OP_START = 3'd1,
		OP_STOP  = 3'd2,
		OP_WRITE = 3'd3,
		OP_READ  = 3'd4,
		OP_WAIT  = 3'd5
	} opcode_t;

	// Sequencer phases
	typedef enum logic [3:0] {
		PH_IDLE,
		PH_S1,
		PH_S2,
		PH_P1,
		PH_P2,
		PH_W_LOW,
		PH_W_HIGH,
		PH_W_TAIL,
		PH_R_LOW,
		PH_R_HIGH,
		PH_A_LOW,
		PH_A_HIGH,
		PH_K1,
		PH_K2,
		PH_K_POLL
	} phase_t;

	// Configuration register indexes
	localparam logic [1:0] REG_SETUP       = 2'd0;
	localparam logic [1:0] REG_HALF_BIT    = 2'd1;
	localparam logic [1:0] REG_SAMPLE_HOLD = 2'd2;
	localparam logic [1:0] REG_ACK_TIMEOUT = 2'd3;

	// Register reset values
	localparam logic [7:0] SETUP_RST       = 8'd4;
	localparam logic [7:0] HALF_BIT_RST    = 8'd2;
	localparam logic [7:0] SAMPLE_HOLD_RST = 8'd1;
	localparam logic [9:0] ACK_TIMEOUT_RST = 10'd250;

	// Bits per byte
	localparam logic [3:0] BYTE_BITS = 4'd8;

	// A hold of zero ticks acts as one tick
	function automatic logic [7:0] hold_len(input logic [7:0] n);
		hold_len = (n == 8'd0) ? 8'd1 : n;
	endfunction

endpackage

// ===== design/i2c_bit_level_master.sv =====
// A tick word is accepted and its pin levels appear on the result in the next cycle.
// Throughput: one tick word per cycle; the sequencer and its counters update in a single
// pass per word, and input ready follows the result register (free or being taken).
// Reset (arst_n low, asynchronous): sequencer idle, SCL and SDA released high with SDA
// driven, registers back to their reset values, no result pending.
// Top level of the I2C bit-level master: tick sequencer and result register.
module i2c_bit_level_master (
	input  logic       clk,
	input  logic       arst_n,
	// configuration write port
	input  logic       cfg_we,
	input  logic [1:0] cfg_index,
	input  logic [9:0] cfg_data,
	// tick word in
	input  logic       in_valid,
	output logic       in_ready,
	input  logic [2:0] opcode,
	input  logic [7:0] write_data,
	input  logic       send_ack,
	input  logic       sda_sample,
	// result word out
	output logic       out_valid,
	input  logic       out_ready,
	output logic       scl_level,
	output logic       sda_level,
	output logic       sda_drive,
	output logic       busy_res,
	output logic       done_res,
	output logic [7:0] read_data,
	output logic       ack_failed
);

	// configuration registers
	logic [7:0] setup_q, half_bit_q, sample_hold_q;
	logic [9:0] ack_timeout_q;

	// sequencer state
	i2cbm_pkg::phase_t  phase_q, phase_d;
	i2cbm_pkg::opcode_t cmd_q, cmd_d;
	logic [3:0] bit_cnt_q, bit_cnt_d;
	logic [7:0] shift_q, shift_d;
	logic [7:0] delay_q, delay_d;
	logic [9:0] tmo_q, tmo_d;
	logic       ack_choice_q, ack_choice_d;
	logic       scl_q, scl_d;
	logic       sda_q, sda_d;
	logic       drive_q, drive_d;
	logic       fail_q, fail_d;
	logic [7:0] read_hold_q, read_hold_d;
	logic       done_d;

	// result register control
	logic       out_valid_q, done_q;
	logic       accept;
	logic [3:0] bit_inc;
	logic [7:0] shift_in;

	assign in_ready = !out_valid_q || out_ready;
	assign accept   = in_valid && in_ready;
	assign bit_inc  = bit_cnt_q + 4'd1;
	assign shift_in = {shift_q[6:0], sda_sample};

	// Configuration writes
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			setup_q       <= i2cbm_pkg::SETUP_RST;
			half_bit_q    <= i2cbm_pkg::HALF_BIT_RST;
			sample_hold_q <= i2cbm_pkg::SAMPLE_HOLD_RST;
			ack_timeout_q <= i2cbm_pkg::ACK_TIMEOUT_RST;
		end else if (cfg_we) begin
			case (cfg_index)
				i2cbm_pkg::REG_SETUP:       setup_q       <= cfg_data[7:0];
				i2cbm_pkg::REG_HALF_BIT:    half_bit_q    <= cfg_data[7:0];
				i2cbm_pkg::REG_SAMPLE_HOLD: sample_hold_q <= cfg_data[7:0];
				i2cbm_pkg::REG_ACK_TIMEOUT: ack_timeout_q <= cfg_data;
				default: ;
			endcase
		end
	end

	// Next state: take a command when idle, else advance the running phase
	always_comb begin
		phase_d      = phase_q;
		cmd_d        = cmd_q;
		bit_cnt_d    = bit_cnt_q;
		shift_d      = shift_q;
		delay_d      = delay_q;
		tmo_d        = tmo_q;
		ack_choice_d = ack_choice_q;
		scl_d        = scl_q;
		sda_d        = sda_q;
		drive_d      = drive_q;
		fail_d       = fail_q;
		read_hold_d  = read_hold_q;
		done_d       = 1'b0;

		if (phase_q == i2cbm_pkg::PH_IDLE) begin
			cmd_d = i2cbm_pkg::opcode_t'(opcode);
			case (opcode)
				i2cbm_pkg::OP_START: begin
					drive_d = 1'b1;
					sda_d   = 1'b1;
					scl_d   = 1'b1;
					phase_d = i2cbm_pkg::PH_S1;
					delay_d = i2cbm_pkg::hold_len(setup_q);
				end
				i2cbm_pkg::OP_STOP: begin
					drive_d = 1'b1;
					scl_d   = 1'b0;
					sda_d   = 1'b0;
					phase_d = i2cbm_pkg::PH_P1;
					delay_d = i2cbm_pkg::hold_len(setup_q);
				end
				i2cbm_pkg::OP_WRITE: begin
					drive_d   = 1'b1;
					scl_d     = 1'b0;
					bit_cnt_d = 4'd0;
					sda_d     = write_data[7];
					shift_d   = {write_data[6:0], 1'b0};
					phase_d   = i2cbm_pkg::PH_W_LOW;
					delay_d   = i2cbm_pkg::hold_len(half_bit_q);
				end
				i2cbm_pkg::OP_READ: begin
					drive_d      = 1'b0;
					sda_d        = 1'b1;
					scl_d        = 1'b0;
					ack_choice_d = send_ack;
					shift_d      = 8'd0;
					bit_cnt_d    = 4'd0;
					phase_d      = i2cbm_pkg::PH_R_LOW;
					delay_d      = i2cbm_pkg::hold_len(half_bit_q);
				end
				i2cbm_pkg::OP_WAIT: begin
					drive_d = 1'b0;
					sda_d   = 1'b1;
					scl_d   = 1'b0;
					tmo_d   = 10'd0;
					fail_d  = 1'b0;
					phase_d = i2cbm_pkg::PH_K1;
					delay_d = i2cbm_pkg::hold_len(sample_hold_q);
				end
				default: cmd_d = i2cbm_pkg::OP_NONE;
			endcase
		end else if (phase_q == i2cbm_pkg::PH_K_POLL) begin
			// poll SDA with SCL high, one poll per tick
			if (!sda_sample) begin
				scl_d  = 1'b0;
				fail_d = 1'b0;
				done_d = 1'b1;
			end else if (tmo_q >= ack_timeout_q) begin
				drive_d = 1'b1;
				scl_d   = 1'b0;
				sda_d   = 1'b0;
				phase_d = i2cbm_pkg::PH_P1;
				delay_d = i2cbm_pkg::hold_len(setup_q);
			end else begin
				tmo_d = tmo_q + 10'd1;
			end
		end else if (delay_q > 8'd1) begin
			delay_d = delay_q - 8'd1;
		end else begin
			delay_d = 8'd0;
			case (phase_q)
				i2cbm_pkg::PH_S1: begin
					sda_d   = 1'b0;
					phase_d = i2cbm_pkg::PH_S2;
					delay_d = i2cbm_pkg::hold_len(setup_q);
				end
				i2cbm_pkg::PH_S2: begin
					scl_d  = 1'b0;
					done_d = 1'b1;
				end
				i2cbm_pkg::PH_P1: begin
					scl_d   = 1'b1;
					sda_d   = 1'b1;
					phase_d = i2cbm_pkg::PH_P2;
					delay_d = i2cbm_pkg::hold_len(setup_q);
				end
				i2cbm_pkg::PH_P2: begin
					if (cmd_q == i2cbm_pkg::OP_WAIT) begin
						fail_d = 1'b1;
					end
					done_d = 1'b1;
				end
				i2cbm_pkg::PH_W_LOW: begin
					scl_d   = 1'b1;
					phase_d = i2cbm_pkg::PH_W_HIGH;
					delay_d = i2cbm_pkg::hold_len(half_bit_q);
				end
				i2cbm_pkg::PH_W_HIGH: begin
					scl_d   = 1'b0;
					phase_d = i2cbm_pkg::PH_W_TAIL;
					delay_d = i2cbm_pkg::hold_len(half_bit_q);
				end
				i2cbm_pkg::PH_W_TAIL: begin
					bit_cnt_d = bit_inc;
					if (bit_inc >= i2cbm_pkg::BYTE_BITS) begin
						done_d = 1'b1;
					end else begin
						sda_d   = shift_q[7];
						shift_d = {shift_q[6:0], 1'b0};
						phase_d = i2cbm_pkg::PH_W_LOW;
						delay_d = i2cbm_pkg::hold_len(half_bit_q);
					end
				end
				i2cbm_pkg::PH_R_LOW: begin
					// SCL rises and the current SDA level shifts in
					scl_d     = 1'b1;
					shift_d   = shift_in;
					bit_cnt_d = bit_inc;
					if (bit_inc >= i2cbm_pkg::BYTE_BITS) begin
						read_hold_d = shift_in;
					end
					phase_d = i2cbm_pkg::PH_R_HIGH;
					delay_d = i2cbm_pkg::hold_len(sample_hold_q);
				end
				i2cbm_pkg::PH_R_HIGH: begin
					scl_d = 1'b0;
					if (bit_cnt_q >= i2cbm_pkg::BYTE_BITS) begin
						drive_d = 1'b1;
						sda_d   = !ack_choice_q;
						phase_d = i2cbm_pkg::PH_A_LOW;
					end else begin
						phase_d = i2cbm_pkg::PH_R_LOW;
					end
					delay_d = i2cbm_pkg::hold_len(half_bit_q);
				end
				i2cbm_pkg::PH_A_LOW: begin
					scl_d   = 1'b1;
					phase_d = i2cbm_pkg::PH_A_HIGH;
					delay_d = i2cbm_pkg::hold_len(half_bit_q);
				end
				i2cbm_pkg::PH_A_HIGH: begin
					scl_d  = 1'b0;
					done_d = 1'b1;
				end
				i2cbm_pkg::PH_K1: begin
					scl_d   = 1'b1;
					phase_d = i2cbm_pkg::PH_K2;
					delay_d = i2cbm_pkg::hold_len(sample_hold_q);
				end
				i2cbm_pkg::PH_K2: phase_d = i2cbm_pkg::PH_K_POLL;
				default: done_d = 1'b1;
			endcase
		end

		// drop back to idle on completion
		if (done_d) begin
			phase_d = i2cbm_pkg::PH_IDLE;
			delay_d = 8'd0;
		end
	end

	// Sequencer registers: advance once per accepted tick word
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q      <= i2cbm_pkg::PH_IDLE;
			cmd_q        <= i2cbm_pkg::OP_NONE;
			bit_cnt_q    <= 4'd0;
			shift_q      <= 8'd0;
			delay_q      <= 8'd0;
			tmo_q        <= 10'd0;
			ack_choice_q <= 1'b0;
			scl_q        <= 1'b1;
			sda_q        <= 1'b1;
			drive_q      <= 1'b1;
			fail_q       <= 1'b0;
			read_hold_q  <= 8'd0;
		end else if (accept) begin
			phase_q      <= phase_d;
			cmd_q        <= cmd_d;
			bit_cnt_q    <= bit_cnt_d;
			shift_q      <= shift_d;
			delay_q      <= delay_d;
			tmo_q        <= tmo_d;
			ack_choice_q <= ack_choice_d;
			scl_q        <= scl_d;
			sda_q        <= sda_d;
			drive_q      <= drive_d;
			fail_q       <= fail_d;
			read_hold_q  <= read_hold_d;
		end
	end

	// Result register: hold the word until taken, reload on accept
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
			done_q      <= 1'b0;
		end else if (accept) begin
			out_valid_q <= 1'b1;
			done_q      <= done_d;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	// Pin levels and status as they stand after the last accepted tick
	assign out_valid  = out_valid_q;
	assign scl_level  = scl_q;
	assign sda_level  = drive_q ? sda_q : 1'b1;
	assign sda_drive  = drive_q;
	assign busy_res   = (phase_q != i2cbm_pkg::PH_IDLE);
	assign done_res   = done_q;
	assign read_data  = read_hold_q;
	assign ack_failed = fail_q;

`ifndef SYNTHESIS
	// A completed command leaves the sequencer idle
	a_done_idle: assert property (@(posedge clk) disable iff (!arst_n)
		done_q |-> (phase_q == i2cbm_pkg::PH_IDLE))
		else $error("done reported while sequencer still busy");

	// The failure flag only rises on the tick a command completes
	a_fail_on_done: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(fail_q) |-> done_q)
		else $error("ack failure flagged without completion");

	// Read and ack-bit phases only run under a read command
	a_read_phase_cmd: assert property (@(posedge clk) disable iff (!arst_n)
		(phase_q == i2cbm_pkg::PH_R_LOW || phase_q == i2cbm_pkg::PH_R_HIGH ||
		 phase_q == i2cbm_pkg::PH_A_LOW || phase_q == i2cbm_pkg::PH_A_HIGH)
		|-> (cmd_q == i2cbm_pkg::OP_READ))
		else $error("read phase active without read command");
`endif

endmodule

// ===== verif/i2cbm_pin_checker.sv =====
// Pin-level predictor and result checker for the I2C bit-level master.
module i2cbm_pin_checker (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       cfg_we,
	input  logic [1:0] cfg_index,
	input  logic [9:0] cfg_data,
	input  logic       in_valid,
	input  logic       in_ready,
	input  logic [2:0] opcode,
	input  logic [7:0] write_data,
	input  logic       send_ack,
	input  logic       sda_sample,
	input  logic       out_valid,
	input  logic       out_ready,
	input  logic       scl_level,
	input  logic       sda_level,
	input  logic       sda_drive,
	input  logic       busy_res,
	input  logic       done_res,
	input  logic [7:0] read_data,
	input  logic       ack_failed,
	output int         mismatches,
	output int         due_count
);

	typedef struct packed {
		logic       scl;
		logic       sda;
		logic       drv;
		logic       busy;
		logic       done;
		logic [7:0] rdata;
		logic       fail;
	} pin_word_t;

	// Timing registers as the block should hold them
	logic [7:0] setup_t, half_t, hold_t;
	logic [9:0] tmo_lim;

	// Sequencer copy
	i2cbm_pkg::phase_t ph;
	logic [2:0] cmd;
	logic [3:0] nbits;
	logic [7:0] shreg, dly, rd_hold;
	logic [9:0] tmo;
	logic       ackc, scl_q, sda_q, drv_q, fail_q;

	pin_word_t pin_words_due[$];

	initial mismatches = 0;

	task automatic reset_model();
		setup_t = i2cbm_pkg::SETUP_RST;
		half_t  = i2cbm_pkg::HALF_BIT_RST;
		hold_t  = i2cbm_pkg::SAMPLE_HOLD_RST;
		tmo_lim = i2cbm_pkg::ACK_TIMEOUT_RST;
		ph      = i2cbm_pkg::PH_IDLE;
		cmd     = i2cbm_pkg::OP_NONE;
		nbits   = '0;
		shreg   = '0;
		dly     = '0;
		tmo     = '0;
		ackc    = 1'b0;
		scl_q   = 1'b1;
		sda_q   = 1'b1;
		drv_q   = 1'b1;
		fail_q  = 1'b0;
		rd_hold = '0;
	endtask

	initial reset_model();

	// Enter a phase; a zero hold counts as one tick
	task automatic hold_phase(input i2cbm_pkg::phase_t p, input logic [7:0] n);
		ph  = p;
		dly = (n == 8'd0) ? 8'd1 : n;
	endtask

	task automatic shift_out_bit();
		sda_q = shreg[7];
		shreg = {shreg[6:0], 1'b0};
		hold_phase(i2cbm_pkg::PH_W_LOW, half_t);
	endtask

	task automatic begin_stop();
		drv_q = 1'b1;
		scl_q = 1'b0;
		sda_q = 1'b0;
		hold_phase(i2cbm_pkg::PH_P1, setup_t);
	endtask

	// Advance the sequencer by one tick and return the pins it leaves behind
	task automatic predict_pins(input logic [2:0] op, input logic [7:0] wd, input logic sa,
			input logic sd, output pin_word_t w);
		logic fin;
		fin = 1'b0;
		if (ph == i2cbm_pkg::PH_IDLE) begin
			cmd = op;
			case (op)
				i2cbm_pkg::OP_START: begin
					drv_q = 1'b1;
					sda_q = 1'b1;
					scl_q = 1'b1;
					hold_phase(i2cbm_pkg::PH_S1, setup_t);
				end
				i2cbm_pkg::OP_STOP: begin
					begin_stop();
				end
				i2cbm_pkg::OP_WRITE: begin
					drv_q = 1'b1;
					scl_q = 1'b0;
					shreg = wd;
					nbits = '0;
					shift_out_bit();
				end
				i2cbm_pkg::OP_READ: begin
					drv_q = 1'b0;
					sda_q = 1'b1;
					scl_q = 1'b0;
					ackc  = sa;
					shreg = '0;
					nbits = '0;
					hold_phase(i2cbm_pkg::PH_R_LOW, half_t);
				end
				i2cbm_pkg::OP_WAIT: begin
					drv_q  = 1'b0;
					sda_q  = 1'b1;
					scl_q  = 1'b0;
					tmo    = '0;
					fail_q = 1'b0;
					hold_phase(i2cbm_pkg::PH_K1, hold_t);
				end
				default: begin
					cmd = i2cbm_pkg::OP_NONE;
				end
			endcase
		end else begin
			if (ph == i2cbm_pkg::PH_K_POLL) begin
				// Poll SDA once per tick with SCL high
				if (!sd) begin
					scl_q  = 1'b0;
					fail_q = 1'b0;
					fin    = 1'b1;
				end else if (tmo >= tmo_lim) begin
					begin_stop();
				end else begin
					tmo = tmo + 10'd1;
				end
			end else if (dly > 8'd1) begin
				dly = dly - 8'd1;
			end else begin
				dly = '0;
				case (ph)
					i2cbm_pkg::PH_S1: begin
						sda_q = 1'b0;
						hold_phase(i2cbm_pkg::PH_S2, setup_t);
					end
					i2cbm_pkg::PH_S2: begin
						scl_q = 1'b0;
						fin   = 1'b1;
					end
					i2cbm_pkg::PH_P1: begin
						scl_q = 1'b1;
						sda_q = 1'b1;
						hold_phase(i2cbm_pkg::PH_P2, setup_t);
					end
					i2cbm_pkg::PH_P2: begin
						if (cmd == i2cbm_pkg::OP_WAIT)
							fail_q = 1'b1;
						fin = 1'b1;
					end
					i2cbm_pkg::PH_W_LOW: begin
						scl_q = 1'b1;
						hold_phase(i2cbm_pkg::PH_W_HIGH, half_t);
					end
					i2cbm_pkg::PH_W_HIGH: begin
						scl_q = 1'b0;
						hold_phase(i2cbm_pkg::PH_W_TAIL, half_t);
					end
					i2cbm_pkg::PH_W_TAIL: begin
						nbits = nbits + 4'd1;
						if (nbits >= i2cbm_pkg::BYTE_BITS)
							fin = 1'b1;
						else
							shift_out_bit();
					end
					i2cbm_pkg::PH_R_LOW: begin
						// Sample on the rising SCL tick
						scl_q = 1'b1;
						shreg = {shreg[6:0], sd};
						nbits = nbits + 4'd1;
						if (nbits >= i2cbm_pkg::BYTE_BITS)
							rd_hold = shreg;
						hold_phase(i2cbm_pkg::PH_R_HIGH, hold_t);
					end
					i2cbm_pkg::PH_R_HIGH: begin
						scl_q = 1'b0;
						if (nbits >= i2cbm_pkg::BYTE_BITS) begin
							drv_q = 1'b1;
							sda_q = !ackc;
							hold_phase(i2cbm_pkg::PH_A_LOW, half_t);
						end else begin
							hold_phase(i2cbm_pkg::PH_R_LOW, half_t);
						end
					end
					i2cbm_pkg::PH_A_LOW: begin
						scl_q = 1'b1;
						hold_phase(i2cbm_pkg::PH_A_HIGH, half_t);
					end
					i2cbm_pkg::PH_A_HIGH: begin
						scl_q = 1'b0;
						fin   = 1'b1;
					end
					i2cbm_pkg::PH_K1: begin
						scl_q = 1'b1;
						hold_phase(i2cbm_pkg::PH_K2, hold_t);
					end
					i2cbm_pkg::PH_K2: begin
						ph = i2cbm_pkg::PH_K_POLL;
					end
					default: begin
						fin = 1'b1;
					end
				endcase
			end
			if (fin) begin
				ph  = i2cbm_pkg::PH_IDLE;
				dly = '0;
			end
		end
		w.scl   = scl_q;
		w.sda   = drv_q ? sda_q : 1'b1;
		w.drv   = drv_q;
		w.busy  = (ph != i2cbm_pkg::PH_IDLE);
		w.done  = fin;
		w.rdata = rd_hold;
		w.fail  = fail_q;
	endtask

	task automatic check_field(input string name, input logic [9:0] want,
			input logic [9:0] got);
		if (want !== got) begin
			mismatches++;
			$display("%0t: %s expected %0h got %0h", $time, name, want, got);
		end
	endtask

	// Compare taken result words, then predict for the tick word taken at this edge
	always @(posedge clk or negedge arst_n) begin
		pin_word_t want, seen;
		if (!arst_n) begin
			reset_model();
			pin_words_due.delete();
		end else begin
			if (cfg_we) begin
				case (cfg_index)
					i2cbm_pkg::REG_SETUP:       setup_t = cfg_data[7:0];
					i2cbm_pkg::REG_HALF_BIT:    half_t  = cfg_data[7:0];
					i2cbm_pkg::REG_SAMPLE_HOLD: hold_t  = cfg_data[7:0];
					i2cbm_pkg::REG_ACK_TIMEOUT: tmo_lim = cfg_data;
					default: ;
				endcase
			end
			if (out_valid && out_ready) begin
				seen = '{scl_level, sda_level, sda_drive, busy_res, done_res,
					read_data, ack_failed};
				if (pin_words_due.size() == 0) begin
					mismatches++;
					$display("%0t: result word expected none got %0h", $time, seen);
				end else begin
					want = pin_words_due.pop_front();
					check_field("scl_level", 10'(want.scl), 10'(seen.scl));
					check_field("sda_level", 10'(want.sda), 10'(seen.sda));
					check_field("sda_drive", 10'(want.drv), 10'(seen.drv));
					check_field("busy_res", 10'(want.busy), 10'(seen.busy));
					check_field("done_res", 10'(want.done), 10'(seen.done));
					check_field("read_data", 10'(want.rdata), 10'(seen.rdata));
					check_field("ack_failed", 10'(want.fail), 10'(seen.fail));
				end
			end
			if (in_valid && in_ready) begin
				predict_pins(opcode, write_data, send_ack, sda_sample, want);
				pin_words_due.push_back(want);
			end
		end
		due_count = pin_words_due.size();
	end

endmodule

// ===== verif/i2c_bit_level_master_test.sv =====
// Stimulus and verdict for the I2C bit-level master, checked by i2cbm_pin_checker.
module i2c_bit_level_master_test;

	// Opcodes outside the command set, ignored by the block
	localparam logic [2:0] OP_SPARE_A = 3'd6;
	localparam logic [2:0] OP_SPARE_B = 3'd7;
	localparam int STALL_LIMIT = 3000;
	// Ticks one command may take before it counts as stuck
	localparam int CMD_TICK_LIMIT = 2000;
	// Long receiver hold-off: earliest cycle and length
	localparam int HOLD_AT = 400;
	localparam int HOLD_LEN = 200;

	logic       clk = 1'b0;
	logic       arst_n;
	logic       cfg_we;
	logic [1:0] cfg_index;
	logic [9:0] cfg_data;
	logic       in_valid, in_ready;
	logic [2:0] opcode;
	logic [7:0] write_data;
	logic       send_ack, sda_sample;
	logic       out_valid, out_ready;
	logic       scl_level, sda_level, sda_drive, busy_res, done_res, ack_failed;
	logic [7:0] read_data;
	int         mismatches, due_count;

	int cycle_no = 0;
	int stall_cycles = 0;
	int dones_taken = 0;
	int commands_sent = 0;
	int hold_left = 0;
	int sda_hi_pct = 50;
	logic held_off = 1'b0;
	logic quiet;

	i2c_bit_level_master uut (
		.clk(clk), .arst_n(arst_n),
		.cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data),
		.in_valid(in_valid), .in_ready(in_ready), .opcode(opcode),
		.write_data(write_data), .send_ack(send_ack), .sda_sample(sda_sample),
		.out_valid(out_valid), .out_ready(out_ready), .scl_level(scl_level),
		.sda_level(sda_level), .sda_drive(sda_drive), .busy_res(busy_res),
		.done_res(done_res), .read_data(read_data), .ack_failed(ack_failed)
	);

	i2cbm_pin_checker pins (
		.clk(clk), .arst_n(arst_n),
		.cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data),
		.in_valid(in_valid), .in_ready(in_ready), .opcode(opcode),
		.write_data(write_data), .send_ack(send_ack), .sda_sample(sda_sample),
		.out_valid(out_valid), .out_ready(out_ready), .scl_level(scl_level),
		.sda_level(sda_level), .sda_drive(sda_drive), .busy_res(busy_res),
		.done_res(done_res), .read_data(read_data), .ack_failed(ack_failed),
		.mismatches(mismatches), .due_count(due_count)
	);

	always #4 clk = ~clk;

	// No idling on either side inside this window
	assign quiet = (cycle_no >= 1000) && (cycle_no < 1400);

	// Count cycles and completions; stop on a long stretch with no word moving
	always @(posedge clk) begin
		cycle_no++;
		if (out_valid && out_ready && done_res)
			dones_taken++;
		if ((in_valid && in_ready) || (out_valid && out_ready))
			stall_cycles = 0;
		else
			stall_cycles++;
		if (stall_cycles >= STALL_LIMIT) begin
			$display("[i2c_bit_level_master] ERROR");
			$finish;
		end
	end

	// Receiver: random stalls, one long hold-off to back up the input
	always @(negedge clk) begin
		if (hold_left > 0) begin
			hold_left--;
			out_ready <= 1'b0;
		end else if (!held_off && cycle_no >= HOLD_AT && in_valid) begin
			held_off = 1'b1;
			hold_left = HOLD_LEN;
			out_ready <= 1'b0;
		end else begin
			out_ready <= quiet || ($urandom_range(99) >= 36);
		end
	end

	function automatic logic rand_sda();
		return $urandom_range(99) < sda_hi_pct;
	endfunction

	// Offer one tick word and hold it until taken
	task automatic send_tick(input logic [2:0] op, input logic [7:0] wd, input logic sa,
			input logic sd);
		while (!quiet && $urandom_range(99) < 36) begin
			in_valid <= 1'b0;
			@(negedge clk);
		end
		in_valid   <= 1'b1;
		opcode     <= op;
		write_data <= wd;
		send_ack   <= sa;
		sda_sample <= sd;
		do
			@(posedge clk);
		while (!in_ready);
		@(negedge clk);
	endtask

	// Tick word whose opcode is ignored even when the block is idle
	task automatic noise_tick();
		logic [2:0] op;
		case ($urandom_range(3))
			0:       op = OP_SPARE_A;
			1:       op = OP_SPARE_B;
			default: op = i2cbm_pkg::OP_NONE;
		endcase
		send_tick(op, 8'($urandom_range(255)), 1'($urandom_range(1)), rand_sda());
	endtask

	// Issue a command on an idle block and tick it until it completes
	task automatic run_cmd(input i2cbm_pkg::opcode_t op, input logic [7:0] wd,
			input logic sa);
		int goal;
		int ticks;
		goal = dones_taken + 1;
		ticks = 0;
		commands_sent++;
		send_tick(op, wd, sa, rand_sda());
		// The next tick always finds the block busy: any opcode is dropped
		send_tick(3'($urandom_range(7)), 8'($urandom_range(255)), 1'($urandom_range(1)),
			rand_sda());
		while (dones_taken < goal) begin
			if (ticks >= CMD_TICK_LIMIT) begin
				$display("[i2c_bit_level_master] ERROR");
				$finish;
			end
			noise_tick();
			ticks++;
		end
	endtask

	// Bus transaction with random content; sometimes left without a stop
	task automatic run_transfer();
		int extra;
		run_cmd(i2cbm_pkg::OP_START, 8'h00, 1'b0);
		run_cmd(i2cbm_pkg::OP_WRITE, 8'($urandom_range(255)), 1'b0);
		run_cmd(i2cbm_pkg::OP_WAIT, 8'h00, 1'b0);
		extra = $urandom_range(2);
		repeat (extra) begin
			if ($urandom_range(1)) begin
				run_cmd(i2cbm_pkg::OP_WRITE, 8'($urandom_range(255)), 1'b0);
				run_cmd(i2cbm_pkg::OP_WAIT, 8'h00, 1'b0);
			end else begin
				run_cmd(i2cbm_pkg::OP_READ, 8'($urandom_range(255)),
					1'($urandom_range(1)));
			end
		end
		if ($urandom_range(4) != 0)
			run_cmd(i2cbm_pkg::OP_STOP, 8'h00, 1'b0);
	endtask

	task automatic write_reg(input logic [1:0] idx, input logic [9:0] val);
		cfg_we    <= 1'b1;
		cfg_index <= idx;
		cfg_data  <= val;
		@(negedge clk);
	endtask

	// Drain all results, then load new timing while the block is idle
	task automatic set_timing(input logic [7:0] setup, input logic [7:0] half,
			input logic [7:0] hold, input logic [9:0] tmo_lim);
		in_valid <= 1'b0;
		while (due_count != 0)
			@(negedge clk);
		repeat (4) @(negedge clk);
		write_reg(i2cbm_pkg::REG_SETUP, {2'b00, setup});
		write_reg(i2cbm_pkg::REG_HALF_BIT, {2'b00, half});
		write_reg(i2cbm_pkg::REG_SAMPLE_HOLD, {2'b00, hold});
		write_reg(i2cbm_pkg::REG_ACK_TIMEOUT, tmo_lim);
		cfg_we <= 1'b0;
	endtask

	task automatic run_phase(input logic [7:0] setup, input logic [7:0] half,
			input logic [7:0] hold, input logic [9:0] tmo_lim, input int pct,
			input int target);
		int goal;
		set_timing(setup, half, hold, tmo_lim);
		sda_hi_pct = pct;
		goal = commands_sent + target;
		while (commands_sent < goal) begin
			if ($urandom_range(99) < 85)
				run_transfer();
			else
				run_cmd(i2cbm_pkg::opcode_t'($urandom_range(i2cbm_pkg::OP_START,
					i2cbm_pkg::OP_WAIT)), 8'($urandom_range(255)),
					1'($urandom_range(1)));
		end
	endtask

	initial begin
		arst_n     = 1'b0;
		cfg_we     = 1'b0;
		cfg_index  = i2cbm_pkg::REG_SETUP;
		cfg_data   = '0;
		in_valid   = 1'b0;
		opcode     = i2cbm_pkg::OP_NONE;
		write_data = '0;
		send_ack   = 1'b0;
		sda_sample = 1'b1;
		out_ready  = 1'b0;
		repeat (3) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;
		@(negedge clk);

		// Directed: ignored opcodes on an idle block, then every command at reset timing
		send_tick(OP_SPARE_A, 8'hFF, 1'b1, 1'b1);
		send_tick(OP_SPARE_B, 8'h00, 1'b0, 1'b0);
		send_tick(i2cbm_pkg::OP_NONE, 8'hA5, 1'b1, 1'b0);
		sda_hi_pct = 0;
		run_cmd(i2cbm_pkg::OP_START, 8'h00, 1'b0);
		run_cmd(i2cbm_pkg::OP_WRITE, 8'h00, 1'b0);
		run_cmd(i2cbm_pkg::OP_WAIT, 8'h00, 1'b0);
		run_cmd(i2cbm_pkg::OP_WRITE, 8'hFF, 1'b1);
		// Acknowledge never comes: time out into a stop
		sda_hi_pct = 100;
		run_cmd(i2cbm_pkg::OP_WAIT, 8'h00, 1'b0);
		run_cmd(i2cbm_pkg::OP_START, 8'h00, 1'b0);
		run_cmd(i2cbm_pkg::OP_READ, 8'h00, 1'b1);
		sda_hi_pct = 0;
		run_cmd(i2cbm_pkg::OP_READ, 8'hFF, 1'b0);
		run_cmd(i2cbm_pkg::OP_WAIT, 8'h00, 1'b0);
		run_cmd(i2cbm_pkg::OP_STOP, 8'h00, 1'b0);

		// Zero holds act as one tick; zero timeout fails on the first high poll
		run_phase(8'd0, 8'd0, 8'd0, 10'd0, 70, 14);
		run_phase(8'd1, 8'd1, 8'd1, 10'd1, 50, 12);
		repeat (2)
			run_phase(8'($urandom_range(1, 4)), 8'($urandom_range(1, 4)),
				8'($urandom_range(1, 4)), 10'($urandom_range(20)), 60, 6);

		// Drain and give the verdict
		in_valid <= 1'b0;
		while (due_count != 0)
			@(negedge clk);
		repeat (4) @(negedge clk);
		if (mismatches == 0)
			$display("[i2c_bit_level_master] OK");
		else
			$display("[i2c_bit_level_master] ERROR");
		$finish;
	end

endmodule
